/* design/wpem_pkg.sv */
package wpem_pkg;

    localparam int POWER_W = 13;
    localparam logic [POWER_W-1:0] POWER_MAX = 13'd8191;
    localparam int WATT_DIVISOR = 11;

    localparam int PFL_W = 10;
    localparam int MWS_W = 16;
    localparam logic [PFL_W-1:0] PFL_RESET = 10'd500;
    localparam logic [MWS_W-1:0] MWS_RESET = 16'd150;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_POWER_FAIL_LEVEL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_WINDOW_SUM = 1'd1;

    typedef enum logic [1:0]
    {
        PWR_HOLD,
        PWR_ZERO,
        PWR_PUSH,
        PWR_LOAD
    } wpem_pwr_op_t;

    typedef struct packed
    {
        logic read;
        logic commit;
    } wpem_win_ctrl_t;

endpackage

/* design/wpem_meas_if.sv */
interface wpem_meas_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   channel;
    logic                   relay_on;

    modport source
    (
        output valid,
        output sample,
        output channel,
        output relay_on,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  sample,
        input  channel,
        input  relay_on,
        output ready
    );
endinterface

/* design/wpem_result_if.sv */
interface wpem_result_if #(
    parameter int ENERGY_BITS = 48
);
    logic                         valid;
    logic                         ready;
    logic [wpem_pkg::POWER_W-1:0] power_watts;
    logic [ENERGY_BITS-1:0]       energy_count;
    logic                         save_request;

    modport source
    (
        output valid,
        output power_watts,
        output energy_count,
        output save_request,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  power_watts,
        input  energy_count,
        input  save_request,
        output ready
    );
endinterface

/* design/wpem_window.sv */
module wpem_window #(
    parameter int WINDOW_LEN  = 50,
    parameter int SAMPLE_BITS = 10,
    parameter int SUM_W       = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  wpem_pkg::wpem_win_ctrl_t ctrl,
    input  logic [SAMPLE_BITS-1:0]   commit_sample,
    output logic [SUM_W-1:0]         sum_next
);

    localparam int PTR_W = $clog2(WINDOW_LEN);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LEN - 1);

    logic [SAMPLE_BITS-1:0] mem_array [WINDOW_LEN];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   rd_valid_reg;
    logic [PTR_W-1:0]       pos_reg;
    logic [PTR_W-1:0]       pos_next;
    logic [PTR_W-1:0]       wr_addr_reg;
    logic                   wrapped_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_BITS-1:0] old_sample;

    // An entry is read before it is rewritten, and the next read
    // always goes to the following entry, so accesses never collide.
    always_ff @(posedge clk)
    begin
        if (ctrl.read)
        begin
            rd_data_reg <= mem_array[pos_reg];
        end
        if (ctrl.commit)
        begin
            mem_array[wr_addr_reg] <= commit_sample;
        end
    end

    always_comb
    begin
        pos_next = (pos_reg == PTR_LAST) ? '0 : pos_reg + 1'b1;
        // Entries not yet written since reset count as zero until the first wrap.
        old_sample = rd_valid_reg ? rd_data_reg : '0;
        sum_next = sum_reg - SUM_W'(old_sample) + SUM_W'(commit_sample);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            wr_addr_reg  <= '0;
            wrapped_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            if (ctrl.read)
            begin
                wr_addr_reg  <= pos_reg;
                rd_valid_reg <= wrapped_reg;
                pos_reg      <= pos_next;
                if (pos_reg == PTR_LAST)
                begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (ctrl.commit)
            begin
                sum_reg <= sum_next;
            end
        end
    end

endmodule

/* design/windowed_power_energy_meter_top.sv */
// Power and energy meter. One sample word is accepted per clock cycle unless
// result.ready holds it back; results pass the s1, s2, s3 and output registers
// in input order, one for every sample. The rate is set by the running window
// sum, which reads the oldest sample from the window memory and writes the new
// one back as its word leaves s1. The window memory needs no clearing pass after
// reset: a wrap flag makes entries not yet written read as zero. Watts are the
// window sum divided by eleven through a reciprocal multiply, and energy is a
// wrapping count of watts. While a result waits, the block keeps accepting words
// until its four stages are full. The user must write configuration through
// cfg_write, cfg_index and cfg_data while the block is idle; it is not enforced.
module windowed_power_energy_meter_top #(
    parameter int WINDOW_LEN  = 50,
    parameter int SAMPLE_BITS = 10,
    parameter int ENERGY_BITS = 48
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [wpem_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wpem_pkg::CFG_DATA_W-1:0]     cfg_data,
    wpem_meas_if.sink                           meas,
    wpem_result_if.source                       result
);

    localparam int SUM_MAX   = WINDOW_LEN * ((2 ** SAMPLE_BITS) - 1);
    localparam int SUM_W     = $clog2(SUM_MAX + 1);
    localparam int DIV_SHIFT = SUM_W + 4;
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int QUOT_W    = PROD_W - DIV_SHIFT;
    localparam int CMP_W     = (QUOT_W > wpem_pkg::POWER_W) ? QUOT_W : wpem_pkg::POWER_W;
    localparam int SUMC_W    = (SUM_W > wpem_pkg::MWS_W) ? SUM_W : wpem_pkg::MWS_W;
    localparam int SMPC_W    = (SAMPLE_BITS > wpem_pkg::PFL_W) ? SAMPLE_BITS : wpem_pkg::PFL_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(wpem_pkg::WATT_DIVISOR - 1)) / 64'(wpem_pkg::WATT_DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic [wpem_pkg::PFL_W-1:0] pfl_reg;
    logic [wpem_pkg::MWS_W-1:0] mws_reg;

    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic accept;

    wpem_pkg::wpem_pwr_op_t in_op;
    logic                   in_save;

    logic                   s1_valid_reg;
    wpem_pkg::wpem_pwr_op_t s1_op_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   s1_save_reg;

    wpem_pkg::wpem_win_ctrl_t win_ctrl;
    logic [SUM_W-1:0]         win_sum_next;

    logic                   s2_valid_reg;
    wpem_pkg::wpem_pwr_op_t s2_op_reg;
    logic [SUM_W-1:0]       s2_sum_reg;
    logic                   s2_save_reg;
    wpem_pkg::wpem_pwr_op_t s2_op_next;
    logic [PROD_W-1:0]      s2_prod_next;

    logic                   s3_valid_reg;
    wpem_pkg::wpem_pwr_op_t s3_op_reg;
    logic [PROD_W-1:0]      s3_prod_reg;
    logic                   s3_save_reg;
    logic [QUOT_W-1:0]      quot;
    logic [wpem_pkg::POWER_W-1:0] watts;

    logic                         out_valid_reg;
    logic [wpem_pkg::POWER_W-1:0] power_reg;
    logic [wpem_pkg::POWER_W-1:0] power_next;
    logic [ENERGY_BITS-1:0]       energy_reg;
    logic [ENERGY_BITS-1:0]       energy_next;
    logic                         save_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pfl_reg <= wpem_pkg::PFL_RESET;
            mws_reg <= wpem_pkg::MWS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                wpem_pkg::CFG_POWER_FAIL_LEVEL: pfl_reg <= cfg_data[wpem_pkg::PFL_W-1:0];
                wpem_pkg::CFG_MIN_WINDOW_SUM:   mws_reg <= cfg_data[wpem_pkg::MWS_W-1:0];
                default:                        ;
            endcase
        end
    end

    always_comb
    begin
        en4 = !out_valid_reg || result.ready;
        en3 = !s3_valid_reg || en4;
        en2 = !s2_valid_reg || en3;
        en1 = !s1_valid_reg || en2;
        accept = meas.valid && en1;

        if (meas.channel)
        begin
            in_op = wpem_pkg::PWR_HOLD;
        end
        else if (!meas.relay_on)
        begin
            in_op = wpem_pkg::PWR_ZERO;
        end
        else if (meas.sample == '0)
        begin
            in_op = wpem_pkg::PWR_HOLD;
        end
        else
        begin
            in_op = wpem_pkg::PWR_PUSH;
        end
        in_save = meas.channel && (SMPC_W'(meas.sample) < SMPC_W'(pfl_reg));

        win_ctrl.read   = accept && (in_op == wpem_pkg::PWR_PUSH);
        win_ctrl.commit = s1_valid_reg && en2 && (s1_op_reg == wpem_pkg::PWR_PUSH);
    end

    assign meas.ready = en1;

    wpem_window #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (win_ctrl),
        .commit_sample (s1_sample_reg),
        .sum_next      (win_sum_next)
    );

    always_comb
    begin
        s2_op_next = s2_op_reg;
        if (s2_op_reg == wpem_pkg::PWR_PUSH)
        begin
            s2_op_next = (SUMC_W'(s2_sum_reg) > SUMC_W'(mws_reg)) ?
                         wpem_pkg::PWR_LOAD : wpem_pkg::PWR_ZERO;
        end
        s2_prod_next = PROD_W'(s2_sum_reg) * PROD_W'(RECIP);
    end

    always_comb
    begin
        quot  = s3_prod_reg[PROD_W-1:DIV_SHIFT];
        watts = (CMP_W'(quot) > CMP_W'(wpem_pkg::POWER_MAX)) ?
                wpem_pkg::POWER_MAX : wpem_pkg::POWER_W'(quot);
        power_next  = power_reg;
        energy_next = energy_reg;
        case (s3_op_reg)
            wpem_pkg::PWR_ZERO:
            begin
                power_next = '0;
            end
            wpem_pkg::PWR_LOAD:
            begin
                power_next  = watts;
                energy_next = energy_reg + ENERGY_BITS'(watts);
            end
            default:
            begin
                power_next = power_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            power_reg     <= '0;
            energy_reg    <= '0;
            save_reg      <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= meas.valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                out_valid_reg <= s3_valid_reg;
                if (s3_valid_reg)
                begin
                    power_reg  <= power_next;
                    energy_reg <= energy_next;
                    save_reg   <= s3_save_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_op_reg     <= in_op;
            s1_sample_reg <= meas.sample;
            s1_save_reg   <= in_save;
        end
        if (en2)
        begin
            s2_op_reg   <= s1_op_reg;
            s2_sum_reg  <= win_sum_next;
            s2_save_reg <= s1_save_reg;
        end
        if (en3)
        begin
            s3_op_reg   <= s2_op_next;
            s3_prod_reg <= s2_prod_next;
            s3_save_reg <= s2_save_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.power_watts  = power_reg;
    assign result.energy_count = energy_reg;
    assign result.save_request = save_reg;

    // The window compare has resolved every push by the last stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_op_reg != wpem_pkg::PWR_PUSH))
    else $error("unresolved push reached the last stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        (en4 && s3_valid_reg && (s3_op_reg == wpem_pkg::PWR_ZERO)) |=> (power_reg == '0))
    else $error("power not cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(en4 && s3_valid_reg && (s3_op_reg == wpem_pkg::PWR_LOAD)) |=> $stable(energy_reg))
    else $error("energy changed without a load");

    assert property (@(posedge clk) disable iff (!rst_n)
        (win_ctrl.read && win_ctrl.commit) |-> (s1_op_reg == wpem_pkg::PWR_PUSH))
    else $error("window commit without a push in flight");

endmodule

/* tb/windowed_power_energy_meter_top_tb.sv */
module windowed_power_energy_meter_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_DEPTH = 50;
    localparam int SAMPLE_W = 10;
    localparam int ENERGY_W = 48;
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 75;
    localparam int LONG_HOLD = 60;
    localparam int DRAIN_CYCLES = 10;
    localparam int DIR_N = 20;

    typedef struct packed
    {
        logic [wpem_pkg::POWER_W-1:0] power_watts;
        logic [ENERGY_W-1:0]          energy_count;
        logic                         save_request;
    } meter_word_t;

    typedef struct packed
    {
        logic [SAMPLE_W-1:0] sample;
        logic                channel;
        logic                relay_on;
        logic                typed;
        meter_word_t         want;
    } stim_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write;
    logic [wpem_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [wpem_pkg::CFG_DATA_W-1:0]  cfg_data;

    wpem_meas_if #(.SAMPLE_BITS(SAMPLE_W)) meas_bus ();
    wpem_result_if #(.ENERGY_BITS(ENERGY_W)) res_bus ();

    windowed_power_energy_meter_top #(
        .WINDOW_LEN  (WIN_DEPTH),
        .SAMPLE_BITS (SAMPLE_W),
        .ENERGY_BITS (ENERGY_W)
    ) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .meas      (meas_bus.sink),
        .result    (res_bus.source)
    );

    // Shadow of the meter state.
    logic [SAMPLE_W-1:0]          win_store [WIN_DEPTH];
    int                           win_total;
    int                           win_pos;
    logic [wpem_pkg::POWER_W-1:0] power_now;
    logic [ENERGY_W-1:0]          energy_now;
    logic [wpem_pkg::PFL_W-1:0]   fail_level_now;
    logic [wpem_pkg::MWS_W-1:0]   min_sum_now;

    meter_word_t pending_words [$];
    int          errors;
    int          words_sent;
    int          words_checked;
    int          idle_pct;
    int          stall_pct;
    int          hold_asks;
    int          holds_served;

    stim_row_t directed_rows [DIR_N] = '{
        '{10'd0,    1'b1, 1'b0, 1'b1, '{13'd0,  48'd0,  1'b1}},
        '{10'd1023, 1'b1, 1'b1, 1'b1, '{13'd0,  48'd0,  1'b0}},
        '{10'd499,  1'b1, 1'b0, 1'b1, '{13'd0,  48'd0,  1'b1}},
        '{10'd500,  1'b1, 1'b1, 1'b1, '{13'd0,  48'd0,  1'b0}},
        '{10'd0,    1'b0, 1'b1, 1'b1, '{13'd0,  48'd0,  1'b0}},
        '{10'd100,  1'b0, 1'b1, 1'b1, '{13'd0,  48'd0,  1'b0}},
        '{10'd50,   1'b0, 1'b1, 1'b1, '{13'd0,  48'd0,  1'b0}},
        '{10'd1,    1'b0, 1'b1, 1'b1, '{13'd13, 48'd13, 1'b0}},
        '{10'd1023, 1'b0, 1'b0, 1'b1, '{13'd0,  48'd13, 1'b0}},
        '{10'd0,    1'b0, 1'b1, 1'b1, '{13'd0,  48'd13, 1'b0}},
        '{10'd1023, 1'b0, 1'b1, 1'b0, '0},
        '{10'd0,    1'b1, 1'b1, 1'b0, '0},
        '{10'd0,    1'b0, 1'b0, 1'b0, '0},
        '{10'd1023, 1'b0, 1'b1, 1'b0, '0},
        '{10'd682,  1'b0, 1'b1, 1'b0, '0},
        '{10'd341,  1'b0, 1'b1, 1'b0, '0},
        '{10'd1023, 1'b1, 1'b0, 1'b0, '0},
        '{10'd512,  1'b0, 1'b1, 1'b0, '0},
        '{10'd1,    1'b0, 1'b1, 1'b0, '0},
        '{10'd1023, 1'b0, 1'b1, 1'b0, '0}
    };

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic meter_word_t meter_step(input logic [SAMPLE_W-1:0] s,
                                               input logic ch, input logic rl);
        meter_word_t w;
        int          watts;
        w.save_request = 1'b0;
        if (ch)
        begin
            w.save_request = (s < fail_level_now);
        end
        else if (rl)
        begin
            if (s != 0)
            begin
                win_total = win_total - int'(win_store[win_pos]) + int'(s);
                win_store[win_pos] = s;
                win_pos = (win_pos == WIN_DEPTH - 1) ? 0 : win_pos + 1;
                if (win_total > int'(min_sum_now))
                begin
                    watts = win_total / wpem_pkg::WATT_DIVISOR;
                    if (watts > int'(wpem_pkg::POWER_MAX))
                    begin
                        watts = int'(wpem_pkg::POWER_MAX);
                    end
                    power_now = wpem_pkg::POWER_W'(watts);
                    energy_now = energy_now + ENERGY_W'(watts);
                end
                else
                begin
                    power_now = '0;
                end
            end
        end
        else
        begin
            power_now = '0;
        end
        w.power_watts = power_now;
        w.energy_count = energy_now;
        return w;
    endfunction

    task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic ch, input logic rl,
                             input logic typed, input meter_word_t want);
        meter_word_t w;
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            meas_bus.valid <= 1'b0;
            @(negedge clk);
        end
        meas_bus.valid <= 1'b1;
        meas_bus.sample <= s;
        meas_bus.channel <= ch;
        meas_bus.relay_on <= rl;
        @(posedge clk);
        while (!meas_bus.ready)
        begin
            @(posedge clk);
        end
        w = meter_step(s, ch, rl);
        pending_words.push_back(typed ? want : w);
        words_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        meas_bus.valid <= 1'b0;
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [wpem_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [wpem_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == wpem_pkg::CFG_POWER_FAIL_LEVEL)
        begin
            fail_level_now = data[wpem_pkg::PFL_W-1:0];
        end
        else if (idx == wpem_pkg::CFG_MIN_WINDOW_SUM)
        begin
            min_sum_now = data;
        end
    endtask

    task automatic random_word(input bit heavy);
        int                  r;
        int                  v;
        logic [SAMPLE_W-1:0] s;
        logic                ch;
        logic                rl;
        r = $urandom_range(0, 99);
        rl = 1'b1;
        ch = 1'b0;
        if (r < 15)
        begin
            ch = 1'b1;
            rl = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1) != 0)
            begin
                v = int'(fail_level_now) + $urandom_range(0, 4) - 2;
                v = (v < 0) ? 0 : (v > 1023) ? 1023 : v;
                s = SAMPLE_W'(v);
            end
            else
            begin
                s = SAMPLE_W'($urandom);
            end
        end
        else if (r < 22)
        begin
            rl = 1'b0;
            s = SAMPLE_W'($urandom);
        end
        else if (r < 27)
        begin
            s = '0;
        end
        else if (heavy)
        begin
            s = ($urandom_range(0, 99) < 90) ? 10'd1023 : SAMPLE_W'($urandom_range(1, 1023));
        end
        else
        begin
            v = $urandom_range(0, 99);
            if (v < 30)
            begin
                s = 10'd1023;
            end
            else if (v < 50)
            begin
                s = SAMPLE_W'($urandom_range(1, 15));
            end
            else
            begin
                s = SAMPLE_W'($urandom_range(1, 1023));
            end
        end
        send_word(s, ch, rl, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        meter_word_t w;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: result word with none expected: power %0d energy %0d save %0d",
                         $time, res_bus.power_watts, res_bus.energy_count,
                         res_bus.save_request);
                errors++;
            end
            else
            begin
                w = pending_words.pop_front();
                words_checked++;
                if (res_bus.power_watts !== w.power_watts)
                begin
                    $display("%0t: power_watts expected %0d actual %0d",
                             $time, w.power_watts, res_bus.power_watts);
                    errors++;
                end
                if (res_bus.energy_count !== w.energy_count)
                begin
                    $display("%0t: energy_count expected %0d actual %0d",
                             $time, w.energy_count, res_bus.energy_count);
                    errors++;
                end
                if (res_bus.save_request !== w.save_request)
                begin
                    $display("%0t: save_request expected %0d actual %0d",
                             $time, w.save_request, res_bus.save_request);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        res_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_asks != holds_served)
            begin
                res_bus.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                holds_served++;
            end
            else
            begin
                res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [wpem_pkg::PFL_W-1:0] pfl_set [PHASES];
        logic [wpem_pkg::MWS_W-1:0] mws_set [PHASES];
        int                         mode;
        pfl_set = '{10'd500, 10'd0, 10'd1023, 10'd1023, 10'd0, 10'd0, 10'd512, 10'd0};
        mws_set = '{16'd150, 16'd0, 16'd51150, 16'd0, 16'd51149, 16'd0, 16'd51149, 16'd0};
        pfl_set[5] = wpem_pkg::PFL_W'($urandom);
        pfl_set[7] = wpem_pkg::PFL_W'($urandom);
        mws_set[5] = wpem_pkg::MWS_W'($urandom_range(0, 51150));
        mws_set[7] = wpem_pkg::MWS_W'($urandom_range(0, 51150));

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        meas_bus.valid = 1'b0;
        meas_bus.sample = '0;
        meas_bus.channel = 1'b0;
        meas_bus.relay_on = 1'b0;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_asks = 0;
        holds_served = 0;
        foreach (win_store[i])
        begin
            win_store[i] = '0;
        end
        win_total = 0;
        win_pos = 0;
        power_now = '0;
        energy_now = '0;
        fail_level_now = wpem_pkg::PFL_RESET;
        min_sum_now = wpem_pkg::MWS_RESET;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
        begin
            send_word(directed_rows[i].sample, directed_rows[i].channel,
                      directed_rows[i].relay_on, directed_rows[i].typed,
                      directed_rows[i].want);
        end
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p != 0)
            begin
                // Upper data bits beyond the fail level width must be dropped.
                write_reg(wpem_pkg::CFG_POWER_FAIL_LEVEL,
                          {wpem_pkg::CFG_DATA_W'($urandom) & 16'hFC00} |
                          wpem_pkg::CFG_DATA_W'(pfl_set[p]));
                write_reg(wpem_pkg::CFG_MIN_WINDOW_SUM, mws_set[p]);
            end
            mode = p % 4;
            idle_pct = (mode == 1) ? 54 : (mode == 3) ? 8 : 0;
            stall_pct = (mode == 2) ? 54 : (mode == 3) ? 8 : 0;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (n == 30 && (p == 0 || p == 4))
                begin
                    hold_asks++;
                end
                random_word(p == 4 || p == 6);
            end
            drain_results();
        end

        idle_pct = 0;
        stall_pct = 0;
        drain_results();
        $display("Sent %0d words (%0d directed) over %0d register settings and idling patterns,",
                 words_sent, DIR_N, PHASES);
        $display("checked %0d result words, including two long output stalls.", words_checked);
        if (errors == 0 && pending_words.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
design/wpem_pkg.sv
design/wpem_meas_if.sv
design/wpem_result_if.sv
design/wpem_window.sv
design/windowed_power_energy_meter_top.sv
tb/windowed_power_energy_meter_top_tb.sv
